// File: hw/rtl/hfc_pkg.sv
`default_nettype none
package hfc_pkg;

	localparam int ROW_W     = 10;
	localparam int DIM_W     = 11;
	localparam int DIM_MAX   = 1024;
	localparam int CFG_W     = 7;
	localparam int D2_W      = 2 * ROW_W + 1;
	localparam int NUM_W     = 32;
	localparam int DEN_W     = 2 * CFG_W;
	localparam int IP_W      = 5;                 // integer bits of the exponent
	localparam int X_W       = 32 + IP_W;
	localparam int Q_W       = 6;
	localparam int EXP_TERMS = 20;
	localparam int FRAC_BITS = 16;
	localparam int GAIN_W    = 20;
	localparam int V_W       = 39;
	localparam int Y_W       = 23;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [31:0] RECIP5  = 32'd858993459;
	localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

	// floor(2^32 / n)
	localparam logic [31:0] RECIP_TAB [2:EXP_TERMS] = '{
		32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
		32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
		32'd429496729,  32'd390451572,  32'd357913941,  32'd330382099,
		32'd306783378,  32'd286331153,  32'd268435456,  32'd252645135,
		32'd238609294,  32'd226050910,  32'd214748364
	};

	localparam int DIV_STAGES = X_W;
	localparam int EXP_STAGES = Q_W + 1 + 3 * (EXP_TERMS - 1);
	localparam int LATENCY    = 3 + DIV_STAGES + EXP_STAGES + 5;

	localparam logic [2:0] REG_GL   = 3'd0;
	localparam logic [2:0] REG_GH   = 3'd1;
	localparam logic [2:0] REG_SL   = 3'd2;
	localparam logic [2:0] REG_CUT  = 3'd3;
	localparam logic [2:0] REG_ROWS = 3'd4;
	localparam logic [2:0] REG_COLS = 3'd5;

	typedef struct packed {
		logic           valid;
		logic           big;
		logic [X_W-1:0] x;
	} div_out_t;

	typedef struct packed {
		logic           valid;
		logic           big;
		logic [Q_W-1:0] q;
		logic [32:0]    sum;
	} exp_out_t;

endpackage
`default_nettype wire

// File: hw/rtl/hfc_div.sv
`default_nettype none
// restoring divider, one quotient bit per stage: x = num * 2^32 / den, num < 32*den
module hfc_div import hfc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output div_out_t              res
);

	logic [DEN_W-1:0] rem_s [0:X_W];
	logic [X_W-1:0]   sh_s  [0:X_W];
	logic             v_s   [0:X_W];
	logic             big_s [0:X_W];

	always_comb begin
		big_s[0] = num >= NUM_W'({den, 5'b0});
		v_s[0]   = in_valid;
		rem_s[0] = big_s[0] ? '0 : num[DEN_W+IP_W-1:IP_W];
		sh_s[0]  = {num[IP_W-1:0], 32'b0};
	end

	genvar k;
	for (k = 1; k <= X_W; k++) begin : g_bit
		logic [DEN_W:0] trial;
		logic           ge;
		assign trial = {rem_s[k-1], sh_s[k-1][X_W-1]};
		assign ge    = trial >= {1'b0, den};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			big_s[k] <= big_s[k-1];
			rem_s[k] <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			sh_s[k]  <= {sh_s[k-1][X_W-2:0], ge};
		end
	end

	assign res.valid = v_s[X_W];
	assign res.big   = big_s[X_W];
	assign res.x     = sh_s[X_W];

endmodule
`default_nettype wire

// File: hw/rtl/hfc_exp.sv
`default_nettype none
// x = q*ln2 + r, then exp(-r) by a Taylor series, three stages per term after the first
module hfc_exp import hfc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  div_out_t   din,
	output exp_out_t   res
);

	logic [X_W-1:0] x_s   [0:Q_W];
	logic [Q_W-1:0] q_s   [0:Q_W];
	logic           v_s   [0:Q_W];
	logic           big_s [0:Q_W];

	assign x_s[0]   = din.x;
	assign q_s[0]   = '0;
	assign v_s[0]   = din.valid;
	assign big_s[0] = din.big;

	genvar k;
	for (k = 1; k <= Q_W; k++) begin : g_red
		localparam logic [X_W-1:0] C = X_W'(LN2_Q32) << (Q_W - k);
		logic ge;
		assign ge = x_s[k-1] >= C;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			big_s[k] <= big_s[k-1];
			x_s[k]   <= ge ? x_s[k-1] - C : x_s[k-1];
			q_s[k]   <= {q_s[k-1][Q_W-2:0], ge};
		end
	end

	// per-term state after term n
	logic [31:0]    term_c [1:EXP_TERMS];
	logic [32:0]    sum_c  [1:EXP_TERMS];
	logic [31:0]    r_c    [1:EXP_TERMS];
	logic [Q_W-1:0] q_c    [1:EXP_TERMS];
	logic           big_c  [1:EXP_TERMS];
	logic           v_c    [1:EXP_TERMS];

	// first term is r itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[1] <= 1'b0;
		end else begin
			v_c[1] <= v_s[Q_W];
		end
	end
	always_ff @(posedge clk) begin
		term_c[1] <= x_s[Q_W][31:0];
		r_c[1]    <= x_s[Q_W][31:0];
		sum_c[1]  <= ONE_Q32 - {1'b0, x_s[Q_W][31:0]};
		q_c[1]    <= q_s[Q_W];
		big_c[1]  <= big_s[Q_W];
	end

	genvar n;
	for (n = 2; n <= EXP_TERMS; n++) begin : g_term
		localparam logic [31:0] RECIP = RECIP_TAB[n];
		localparam logic [36:0] NC    = 37'(n);
		localparam bit          ODD   = (n % 2) == 1;

		logic           v_a, v_b;
		logic [31:0]    hi_a, hi_b, qe_b, sr_a, sr_b;
		logic [32:0]    sum_a, sum_b;
		logic [Q_W-1:0] q_a, q_b;
		logic           big_a, big_b;
		logic [63:0]    prod, pm;
		logic [36:0]    rem;
		logic [31:0]    tq;
		logic [33:0]    acc;
		logic [32:0]    nsum;

		assign prod = 64'(term_c[n-1]) * 64'(r_c[n-1]);
		assign pm   = 64'(hi_a) * 64'(RECIP);

		always_comb begin
			rem  = {5'b0, hi_b} - 37'(qe_b) * NC;
			tq   = (rem >= NC) ? qe_b + 32'd1 : qe_b;
			acc  = {1'b0, sum_b} + {2'b0, tq};
			if (ODD) begin
				nsum = ({1'b0, tq} > sum_b) ? '0 : sum_b - {1'b0, tq};
			end else begin
				nsum = (acc > {1'b0, ONE_Q32}) ? ONE_Q32 : acc[32:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_a    <= 1'b0;
				v_b    <= 1'b0;
				v_c[n] <= 1'b0;
			end else begin
				v_a    <= v_c[n-1];
				v_b    <= v_a;
				v_c[n] <= v_b;
			end
		end
		always_ff @(posedge clk) begin
			hi_a      <= prod[63:32];
			sr_a      <= r_c[n-1];
			sum_a     <= sum_c[n-1];
			q_a       <= q_c[n-1];
			big_a     <= big_c[n-1];
			hi_b      <= hi_a;
			qe_b      <= pm[63:32];
			sr_b      <= sr_a;
			sum_b     <= sum_a;
			q_b       <= q_a;
			big_b     <= big_a;
			term_c[n] <= tq;
			sum_c[n]  <= nsum;
			r_c[n]    <= sr_b;
			q_c[n]    <= q_b;
			big_c[n]  <= big_b;
		end
	end

	assign res.valid = v_c[EXP_TERMS];
	assign res.big   = big_c[EXP_TERMS];
	assign res.q     = q_c[EXP_TERMS];
	assign res.sum   = sum_c[EXP_TERMS];

endmodule
`default_nettype wire

// File: hw/rtl/homomorphic_filter_coefficient.sv
// channel   | signals                          | direction
// config    | psel penable pwrite paddr pwdata | in, prdata pready out
// sample    | start row col                    | in, busy out (always low)
// gain      | done gain                        | out, one-cycle strobe
//
// One sample enters per cycle; its gain comes out on gain with done after the pipeline.
// The depth is set by the 37-stage quotient divider and the 20-term exp series.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
// No back-pressure: the pipeline never stalls and busy stays low.
`default_nettype none
module homomorphic_filter_coefficient import hfc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ROW_W-1:0]  row,
	input  wire logic [ROW_W-1:0]  col,
	output logic                   done,
	output logic [GAIN_W-1:0]      gain
);

	logic [CFG_W-1:0] gl_q, gh_q, sl_q, cut_q;
	logic [DIM_W-1:0] rows_q, cols_q;
	logic [DEN_W-1:0] den_q;
	logic [10:0]      sl10_q;
	logic             wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gl_q   <= 7'd10;
			gh_q   <= 7'd20;
			sl_q   <= 7'd60;
			cut_q  <= 7'd70;
			rows_q <= 11'd1024;
			cols_q <= 11'd1024;
		end else if (wr) begin
			case (paddr[4:2])
				REG_GL:   gl_q   <= pwdata[CFG_W-1:0];
				REG_GH:   gh_q   <= pwdata[CFG_W-1:0];
				REG_SL:   sl_q   <= pwdata[CFG_W-1:0];
				REG_CUT:  cut_q  <= pwdata[CFG_W-1:0];
				REG_ROWS: rows_q <= pwdata[DIM_W-1:0];
				REG_COLS: cols_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GL:   prdata = 32'(gl_q);
			REG_GH:   prdata = 32'(gh_q);
			REG_SL:   prdata = 32'(sl_q);
			REG_CUT:  prdata = 32'(cut_q);
			REG_ROWS: prdata = 32'(rows_q);
			REG_COLS: prdata = 32'(cols_q);
			default:  prdata = '0;
		endcase
	end

	// derived settings, registered from the config registers
	logic [CFG_W-1:0] d0;
	assign d0 = (cut_q == '0) ? CFG_W'(1) : cut_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q  <= 14'd4900;
			sl10_q <= 11'd600;
		end else begin
			den_q  <= DEN_W'(d0) * DEN_W'(d0);
			sl10_q <= 11'(sl_q) * 11'd10;
		end
	end

	// centre
	logic [DIM_W-1:0] rcl, ccl;
	logic [ROW_W-1:0] rh, ch;
	assign rcl = (rows_q > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : rows_q;
	assign ccl = (cols_q > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : cols_q;
	assign rh  = rcl[DIM_W-1:1];
	assign ch  = ccl[DIM_W-1:1];

	logic             v_s1, v_s2, v_s3;
	logic [ROW_W-1:0] dr_s1, dc_s1;
	logic [D2_W-1:0]  d2_s2;
	logic [NUM_W-1:0] num_s3;
	logic             acc_in;
	assign acc_in = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= acc_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		dr_s1  <= (row >= rh) ? row - rh : rh - row;
		dc_s1  <= (col >= ch) ? col - ch : ch - col;
		d2_s2  <= D2_W'(dr_s1) * D2_W'(dr_s1) + D2_W'(dc_s1) * D2_W'(dc_s1);
		num_s3 <= NUM_W'(d2_s2) * NUM_W'(sl10_q);
	end

	div_out_t dv;
	exp_out_t ex;

	hfc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.num      (num_s3),
		.den      (den_q),
		.res      (dv)
	);

	hfc_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (dv),
		.res    (ex)
	);

	// back end: shift by q, blend, scale by 2^FRAC_BITS / 10 with rounding
	logic              v_se, v_sv, v_sy, v_sm;
	logic [32:0]       e_se;
	logic [V_W-1:0]    v_sv_val;
	logic [Y_W-1:0]    y_sy, y_sm, qe_sm;
	logic [39:0]       vmix;
	logic [55:0]       w;
	logic [54:0]       pm5;
	logic [Y_W-1:0]    rem5, gq;

	assign vmix = 40'(gl_q) * 40'(e_se) + 40'(gh_q) * 40'(ONE_Q32 - e_se);
	assign w    = (56'(v_sv_val) << FRAC_BITS) + (56'(5) << 32);
	assign pm5  = 55'(y_sy) * 55'(RECIP5);
	assign rem5 = y_sm - Y_W'(qe_sm * Y_W'(5));
	assign gq   = (rem5 >= Y_W'(5)) ? qe_sm + Y_W'(1) : qe_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_se <= 1'b0;
			v_sv <= 1'b0;
			v_sy <= 1'b0;
			v_sm <= 1'b0;
			done <= 1'b0;
		end else begin
			v_se <= ex.valid;
			v_sv <= v_se;
			v_sy <= v_sv;
			v_sm <= v_sy;
			done <= v_sm;
		end
	end
	always_ff @(posedge clk) begin
		e_se     <= ex.big ? '0 : ex.sum >> ex.q;
		v_sv_val <= vmix[V_W-1:0];
		y_sy     <= w[55:33];
		y_sm     <= y_sy;
		qe_sm    <= pm5[54:32];
		gain     <= (gq > Y_W'(GAIN_MAX)) ? GAIN_MAX : gq[GAIN_W-1:0];
	end

endmodule
`default_nettype wire

// File: hw/rtl/hfc_chk.sv
`default_nettype none
module hfc_chk import hfc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [4:0]        paddr,
	input wire logic [31:0]       pwdata,
	input wire logic [31:0]       prdata,
	input wire logic              pready,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [GAIN_W-1:0] gain
);

	logic wr_gl, rd_gl;
	assign wr_gl = psel && penable && pwrite && pready && paddr[4:2] == REG_GL;
	assign rd_gl = psel && !pwrite && paddr[4:2] == REG_GL;

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word gave no gain");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("gain strobe without a word");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		wr_gl ##1 rd_gl |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
		else $error("register readback mismatch");

	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> gain <= GAIN_W'(832308))
		else $error("gain beyond 12.7");

endmodule

bind homomorphic_filter_coefficient hfc_chk u_chk (.*);
`default_nettype wire
